// ===== rtl/sync_length_deframer_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the sync-length deframer
// Short wrappers for clocked concurrent assertions, reset-qualified.
// ---------------------------------------------------------------------------
`ifndef SYNC_LENGTH_DEFRAMER_MACROS_SVH
`define SYNC_LENGTH_DEFRAMER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define SLD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");

// Check that the consequent holds in the cycle after the antecedent
`define SLD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");

`endif

// ===== rtl/sld_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer package
// Field widths, frame constants, sync word lookup and the queued result token.
// ---------------------------------------------------------------------------
package sld_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 17;
    localparam int LENGTH_W = 16;
    localparam int SYNC_LEN = 8;
    localparam int SYNC_IDX_W = 3;

    localparam logic [OFFSET_W-1:0] HEADER_BYTES = 17'd10;

    // One queued result: either a single frame byte or a whole sync word
    typedef struct packed {
        logic                is_sync;
        logic [BYTE_W-1:0]   data;
        logic [OFFSET_W-1:0] offset;
        logic                last;
        logic [OFFSET_W-1:0] length;
    } t_token;

    // Sync word 00 FF FF FF FF FF FF 00
    function automatic logic [BYTE_W-1:0] sync_byte(input logic [SYNC_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] res;
        if (idx == 3'd0 || idx == 3'(SYNC_LEN - 1)) begin
            res = 8'h00;
        end else begin
            res = 8'hFF;
        end
        return res;
    endfunction

endpackage

// ===== rtl/sld_in_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer input channel
// Valid/ready stream carrying one received byte per transfer.
// ---------------------------------------------------------------------------
interface sld_in_if;
    logic                        valid;
    logic                        ready;
    logic [sld_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== rtl/sld_out_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer output channel
// Valid/ready stream carrying one frame byte with its position and marks.
// ---------------------------------------------------------------------------
interface sld_out_if;
    logic                          valid;
    logic                          ready;
    logic [sld_pkg::BYTE_W-1:0]    out_byte;
    logic [sld_pkg::OFFSET_W-1:0]  byte_offset;
    logic                          frame_first;
    logic                          frame_last;
    logic [sld_pkg::OFFSET_W-1:0]  frame_length;

    modport source (output valid, output out_byte, output byte_offset,
                    output frame_first, output frame_last, output frame_length,
                    input ready);
    modport sink   (input valid, input out_byte, input byte_offset,
                    input frame_first, input frame_last, input frame_length,
                    output ready);
endinterface

// ===== rtl/sld_tok_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Deframer token queue
// Small register FIFO of result tokens between the parser and the output.
// ---------------------------------------------------------------------------
module sld_tok_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sld_pkg::t_token i_push_data,
    input  logic            i_pop,
    output sld_pkg::t_token o_head,
    output logic            o_empty,
    output logic            o_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    sld_pkg::t_token r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]   r_count,  n_count;

    assign o_head  = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);

    // Advance pointers and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store tokens
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

// ===== rtl/sync_length_deframer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Sync-length deframer
// Finds 00 FF FF FF FF FF FF 00, reads a 16-bit big-endian body length and
// passes the whole frame (header included) out one byte per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   i_in carries one received byte per transfer; o_out carries frame bytes
//   with byte_offset, frame_first, frame_last and frame_length.
//   No output is given while hunting. When the eighth sync byte arrives the
//   eight sync bytes are released on eight consecutive output transfers;
//   length and body bytes then follow one for one.
//   A byte accepted into the input register is parsed and its token pushed into
//   the queue; it reaches o_out from the queue head after the tokens ahead of it.
//   Throughput: one input byte per cycle while the queue has room, set by the parser step
//   between the input register and the token queue. A sync word is one queue
//   token that the output side expands into eight output transfers; the DEPTH-entry
//   queue (nine by default) holds that token and the bytes that arrive while
//   it expands, so the input stalls only when the receiver does.
//   Reset: parser returns to hunting, the input register and queue empty.
//   When the receiver stalls, results collect in the queue and then the
//   input is held off; nothing is dropped.
// ---------------------------------------------------------------------------
`include "sync_length_deframer_macros.svh"

module sync_length_deframer #(
    parameter int DEPTH = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    sld_in_if.sink           i_in,
    sld_out_if.source        o_out
);

    localparam logic [1:0] PH_HUNT   = 2'd0;
    localparam logic [1:0] PH_LEN_HI = 2'd1;
    localparam logic [1:0] PH_LEN_LO = 2'd2;
    localparam logic [1:0] PH_BODY   = 2'd3;

    localparam logic [sld_pkg::SYNC_IDX_W-1:0] SYNC_LAST = 3'(sld_pkg::SYNC_LEN - 1);
    localparam logic [sld_pkg::OFFSET_W-1:0]   SYNC_POS  = 17'(sld_pkg::SYNC_LEN);

    // Input register
    logic                                r_in_valid, n_in_valid;
    logic [sld_pkg::BYTE_W-1:0]          r_in_byte;

    // Parser state
    logic [1:0]                          r_phase, n_phase;
    logic [sld_pkg::SYNC_IDX_W-1:0]      r_sync_matched, n_sync_matched;
    logic [sld_pkg::BYTE_W-1:0]          r_length_high, n_length_high;
    logic [sld_pkg::LENGTH_W-1:0]        r_body_remaining, n_body_remaining;
    logic [sld_pkg::OFFSET_W-1:0]        r_frame_position, n_frame_position;

    // Output expansion
    logic [sld_pkg::SYNC_IDX_W-1:0]      r_burst_idx, n_burst_idx;

    logic                                w_step;
    logic                                w_accept;
    logic                                w_push;
    sld_pkg::t_token                     w_tok;
    sld_pkg::t_token                     w_head;
    logic                                w_empty;
    logic                                w_full;
    logic                                w_out_xfer;
    logic                                w_pop;
    logic [sld_pkg::LENGTH_W-1:0]        w_len_word;
    logic [sld_pkg::LENGTH_W-1:0]        w_rem_dec;

    // Consume the held byte whenever the queue has room
    assign w_step     = r_in_valid && !w_full;
    assign i_in.ready = !r_in_valid || w_step;
    assign w_accept   = i_in.valid && i_in.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_step) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in.in_byte;
        end
    end

    // Parse one byte: update state and build the result token
    assign w_len_word = {r_length_high, r_in_byte};
    assign w_rem_dec  = r_body_remaining - 1'b1;

    always_comb begin
        n_phase          = r_phase;
        n_sync_matched   = r_sync_matched;
        n_length_high    = r_length_high;
        n_body_remaining = r_body_remaining;
        n_frame_position = r_frame_position;
        w_push           = 1'b0;
        w_tok.is_sync    = 1'b0;
        w_tok.data       = r_in_byte;
        w_tok.offset     = r_frame_position;
        w_tok.last       = 1'b0;
        w_tok.length     = '0;
        if (w_step) begin
            unique case (r_phase)
                PH_LEN_HI: begin
                    w_push           = 1'b1;
                    n_length_high    = r_in_byte;
                    n_frame_position = r_frame_position + 1'b1;
                    n_phase          = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    w_push           = 1'b1;
                    n_body_remaining = w_len_word;
                    if (w_len_word == '0) begin
                        w_tok.last       = 1'b1;
                        w_tok.length     = sld_pkg::HEADER_BYTES;
                        n_frame_position = '0;
                        n_sync_matched   = '0;
                        n_phase          = PH_HUNT;
                    end else begin
                        n_frame_position = r_frame_position + 1'b1;
                        n_phase          = PH_BODY;
                    end
                end
                PH_BODY: begin
                    w_push           = 1'b1;
                    n_body_remaining = w_rem_dec;
                    if (w_rem_dec == '0) begin
                        w_tok.last       = 1'b1;
                        w_tok.length     = r_frame_position + 1'b1;
                        n_frame_position = '0;
                        n_sync_matched   = '0;
                        n_phase          = PH_HUNT;
                    end else begin
                        n_frame_position = r_frame_position + 1'b1;
                    end
                end
                default: begin
                    // Hunt one byte per step; a breaking byte may start a new match
                    if (r_in_byte == sld_pkg::sync_byte(r_sync_matched)) begin
                        if (r_sync_matched == SYNC_LAST) begin
                            w_push           = 1'b1;
                            w_tok.is_sync    = 1'b1;
                            n_frame_position = SYNC_POS;
                            n_sync_matched   = '0;
                            n_phase          = PH_LEN_HI;
                        end else begin
                            n_sync_matched = r_sync_matched + 1'b1;
                        end
                    end else begin
                        n_sync_matched = (r_in_byte == 8'h00) ? 3'd1 : 3'd0;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HUNT;
            r_sync_matched   <= '0;
            r_length_high    <= '0;
            r_body_remaining <= '0;
            r_frame_position <= '0;
        end else begin
            r_phase          <= n_phase;
            r_sync_matched   <= n_sync_matched;
            r_length_high    <= n_length_high;
            r_body_remaining <= n_body_remaining;
            r_frame_position <= n_frame_position;
        end
    end

    // Queue results between parser and output
    sld_tok_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_tok),
        .i_pop       (w_pop),
        .o_head      (w_head),
        .o_empty     (w_empty),
        .o_full      (w_full)
    );

    // Expand the head token onto the output channel
    assign o_out.valid        = !w_empty;
    assign o_out.out_byte     = w_head.is_sync ? sld_pkg::sync_byte(r_burst_idx) : w_head.data;
    assign o_out.byte_offset  = w_head.is_sync ? 17'(r_burst_idx) : w_head.offset;
    assign o_out.frame_first  = w_head.is_sync && (r_burst_idx == '0);
    assign o_out.frame_last   = !w_head.is_sync && w_head.last;
    assign o_out.frame_length = w_head.is_sync ? '0 : w_head.length;

    assign w_out_xfer = o_out.valid && o_out.ready;
    assign w_pop      = w_out_xfer && (!w_head.is_sync || r_burst_idx == SYNC_LAST);

    always_comb begin
        n_burst_idx = r_burst_idx;
        if (w_out_xfer && w_head.is_sync) begin
            n_burst_idx = (r_burst_idx == SYNC_LAST) ? '0 : r_burst_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_idx <= '0;
        end else begin
            r_burst_idx <= n_burst_idx;
        end
    end

    // Checks
    `SLD_ASSERT_SAME(a_last_len, i_clk, i_rst_n, o_out.valid && o_out.frame_last,
                     o_out.frame_length == o_out.byte_offset + 17'd1)
    `SLD_ASSERT_NEXT(a_hold_in, i_clk, i_rst_n, r_in_valid && !w_step,
                     r_in_valid && $stable(r_in_byte))
    `SLD_ASSERT_SAME(a_burst_head, i_clk, i_rst_n, r_burst_idx != 3'd0,
                     o_out.valid && w_head.is_sync)

endmodule
